// ===== rtl/dts_pkg.sv =====
// Shared constants, types and register indexes of the delimiter text splitter.
package dts_pkg;

    localparam int WIN_BYTES   = 4;
    localparam int SLOTS       = 4;
    localparam int OFFSET_BITS = 20;
    localparam int NRES        = 4;
    localparam int DELIM_BITS  = 8 * WIN_BYTES;
    localparam int LEN_CODE_W  = 3;
    localparam int FILL_W      = 2;
    localparam int POS_W       = OFFSET_BITS + 1;
    localparam int NUM_W       = 2;
    localparam int CNT_W       = 3;

    localparam logic [POS_W-1:0]       POS_LIMIT = POS_W'(1) << OFFSET_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX   = '1;

    typedef enum logic [2:0] {
        REG_DELIM0  = 3'd0,
        REG_DELIM1  = 3'd1,
        REG_DELIM2  = 3'd2,
        REG_DELIM3  = 3'd3,
        REG_LENGTHS = 3'd4,
        REG_COUNT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SLOTS-1:0][DELIM_BITS-1:0] bytes;
        logic [SLOTS*LEN_CODE_W-1:0]      lens;
        logic [CNT_W-1:0]                 count;
    } cfg_t;

    typedef struct packed {
        logic                  hit;
        logic [NUM_W-1:0]      num;
        logic [LEN_CODE_W-1:0] len;
    } hit_t;

    typedef struct packed {
        logic                   too_long;
        logic                   final_chunk;
        logic [NUM_W-1:0]       delimiter_number;
        logic                   ended_by_delimiter;
        logic [POS_W-1:0]       chunk_length;
        logic [OFFSET_BITS-1:0] chunk_offset;
    } res_t;

endpackage

// ===== rtl/delimiter_text_splitter_core.sv =====
// Top level of the delimiter text splitter: state, chunk chaining, result buffer.
//
// Text enters one byte per beat and a position is tried once the four bytes from it are
// known, so a delimiter that starts at byte p is decided on the beat that carries byte
// p+3, or on the end-of-text beat; its chunk enters the result buffer on that beat and
// shows on m_ the cycle after if first of that beat, else once earlier results drain.
// The window compare, the match chain and the result build are combinational and sit
// between the text state registers and a four-entry result buffer. While m_tready
// is high, a byte that yields one result or none is followed by the next byte in the
// next cycle; while a result waits on m_tready the input holds. The end-of-text beat
// yields up to four results; the input then holds while the buffer drains.
module delimiter_text_splitter_core import dts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [19:0] chunk_offset, [40:20] chunk_length, zero pad
    output logic [3:0]  m_tuser,   // [0] ended_by_delimiter, [2:1] delimiter_number,
                                   // [3] too_long
    output logic        m_tlast
);

    cfg_t cfg_reg;

    logic [WIN_BYTES-2:0][7:0] win_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [OFFSET_BITS-1:0]    start_reg;
    logic [FILL_W-1:0]         skip_reg;
    logic                      ovf_reg;

    res_t [NRES-1:0]           obuf_reg;
    logic [CNT_W-1:0]          ocnt_reg;

    logic [WIN_BYTES-1:0][7:0] buf_c;
    logic [CNT_W-1:0]          n_c;
    logic [POS_W-1:0]          pos_next;
    logic                      ovf_next;
    hit_t [WIN_BYTES-1:0]      hits;
    res_t [NRES-1:0]           res_c;
    logic [CNT_W-1:0]          k_c;
    logic [OFFSET_BITS-1:0]    start_next;
    logic [FILL_W-1:0]         skip_next;
    logic                      s_acc;
    logic                      m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    assign ovf_next = ovf_reg | pos_reg[OFFSET_BITS];
    assign pos_next = pos_reg[OFFSET_BITS] ? pos_reg : pos_reg + POS_W'(1);
    assign n_c      = CNT_W'(fill_reg) + CNT_W'(1);

    always_comb begin
        for (int i = 0; i < WIN_BYTES; i++) begin
            if (i < WIN_BYTES - 1 && FILL_W'(i) < fill_reg) begin
                buf_c[i] = win_reg[i];
            end else if (CNT_W'(i) == CNT_W'(fill_reg)) begin
                buf_c[i] = s_tdata;
            end else begin
                buf_c[i] = 8'h00;
            end
        end
    end

    dts_match u_match (
        .win_bytes (buf_c),
        .win_count (n_c),
        .cfg       (cfg_reg),
        .hits      (hits)
    );

    always_comb begin
        logic [POS_W-1:0]       base;
        logic [POS_W-1:0]       q;
        logic [POS_W:0]         sum;
        logic [POS_W-1:0]       cend;
        logic [OFFSET_BITS-1:0] st;
        logic [FILL_W-1:0]      sk;
        logic [CNT_W-1:0]       k;
        logic                   act;
        base  = pos_next - POS_W'(n_c);
        q     = '0;
        sum   = '0;
        cend  = '0;
        st    = start_reg;
        sk    = skip_reg;
        k     = '0;
        act   = 1'b0;
        res_c = '0;
        for (int i = 0; i < WIN_BYTES; i++) begin
            act = s_tlast ? (CNT_W'(i) < n_c) : (i == 0 && n_c == CNT_W'(WIN_BYTES));
            q   = base + POS_W'(i);
            if (act) begin
                if (sk != '0) begin
                    sk = sk - FILL_W'(1);
                end else if (hits[i].hit) begin
                    sum  = {1'b0, q} + (POS_W+1)'(hits[i].len);
                    cend = (sum > {1'b0, POS_LIMIT}) ? POS_LIMIT : sum[POS_W-1:0];
                    res_c[k[1:0]].chunk_offset       = st;
                    res_c[k[1:0]].chunk_length       =
                        (cend > {1'b0, st}) ? cend - {1'b0, st} : '0;
                    res_c[k[1:0]].ended_by_delimiter = 1'b1;
                    res_c[k[1:0]].delimiter_number   = hits[i].num;
                    res_c[k[1:0]].too_long           = ovf_next;
                    k  = k + CNT_W'(1);
                    st = (cend < {1'b0, OFF_MAX}) ? cend[OFFSET_BITS-1:0] : OFF_MAX;
                    sk = FILL_W'(hits[i].len - LEN_CODE_W'(1));
                end
            end
        end
        if (s_tlast) begin
            if (k < CNT_W'(NRES)) begin
                res_c[k[1:0]].chunk_offset       = st;
                res_c[k[1:0]].chunk_length       =
                    (pos_next > {1'b0, st}) ? pos_next - {1'b0, st} : '0;
                res_c[k[1:0]].ended_by_delimiter = 1'b0;
                res_c[k[1:0]].delimiter_number   = '0;
                res_c[k[1:0]].too_long           = ovf_next;
                k = k + CNT_W'(1);
            end
            res_c[k[1:0] - 2'd1].final_chunk = 1'b1;
        end
        k_c        = k;
        start_next = st;
        skip_next  = sk;
    end

    assign s_tready = (ocnt_reg == '0) || (ocnt_reg == CNT_W'(1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bytes[0] <= 32'd2570;
            cfg_reg.bytes[1] <= 32'd10;
            cfg_reg.bytes[2] <= 32'd9;
            cfg_reg.bytes[3] <= 32'd8238;
            cfg_reg.lens     <= 12'd1098;
            cfg_reg.count    <= 3'd3;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DELIM0:  cfg_reg.bytes[0] <= cfg_wdata;
                REG_DELIM1:  cfg_reg.bytes[1] <= cfg_wdata;
                REG_DELIM2:  cfg_reg.bytes[2] <= cfg_wdata;
                REG_DELIM3:  cfg_reg.bytes[3] <= cfg_wdata;
                REG_LENGTHS: cfg_reg.lens     <= cfg_wdata[SLOTS*LEN_CODE_W-1:0];
                REG_COUNT:   cfg_reg.count    <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            skip_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else if (s_acc) begin
            if (s_tlast) begin
                fill_reg  <= '0;
                pos_reg   <= '0;
                start_reg <= '0;
                skip_reg  <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                fill_reg  <= (n_c == CNT_W'(WIN_BYTES)) ? FILL_W'(WIN_BYTES - 1)
                                                        : FILL_W'(n_c);
                pos_reg   <= pos_next;
                start_reg <= start_next;
                skip_reg  <= skip_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !s_tlast) begin
            if (n_c == CNT_W'(WIN_BYTES)) begin
                win_reg <= buf_c[WIN_BYTES-1:1];
            end else begin
                win_reg[fill_reg] <= s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= '0;
        end else if (s_acc) begin
            ocnt_reg <= k_c;
        end else if (m_acc) begin
            ocnt_reg <= ocnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            obuf_reg <= res_c;
        end else if (m_acc) begin
            obuf_reg <= {res_t'('0), obuf_reg[NRES-1:1]};
        end
    end

    assign m_tvalid = (ocnt_reg != '0);
    assign m_tdata  = {7'b0, obuf_reg[0].chunk_length, obuf_reg[0].chunk_offset};
    assign m_tuser  = {obuf_reg[0].too_long, obuf_reg[0].delimiter_number,
                       obuf_reg[0].ended_by_delimiter};
    assign m_tlast  = obuf_reg[0].final_chunk;

    a_skip_full_window: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg != '0 |-> fill_reg == FILL_W'(WIN_BYTES - 1))
        else $error("skip pending without a full window");

    a_fill_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        POS_W'(fill_reg) <= pos_reg)
        else $error("window holds more bytes than received");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> pos_reg == '0 && fill_reg == '0 && start_reg == '0)
        else $error("text state not cleared after end of text");

    a_final_last_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> ocnt_reg == CNT_W'(1))
        else $error("final beat is not the last buffered result");

    a_accept_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result buffer");

endmodule

// ===== rtl/dts_match.sv =====
// Parallel delimiter compare at every position of the lookahead window.
module dts_match import dts_pkg::*; (
    input  logic [WIN_BYTES-1:0][7:0] win_bytes,
    input  logic [CNT_W-1:0]          win_count,
    input  cfg_t                      cfg,
    output hit_t [WIN_BYTES-1:0]      hits
);

    logic [2*WIN_BYTES-2:0][7:0] ext;

    assign ext = {{(WIN_BYTES-1){8'h00}}, win_bytes};

    always_comb begin
        logic [CNT_W-1:0]      used;
        logic [CNT_W-1:0]      avail;
        logic [LEN_CODE_W-1:0] dl;
        logic                  ok;
        used  = (cfg.count > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg.count;
        avail = '0;
        dl    = '0;
        ok    = 1'b0;
        for (int i = 0; i < WIN_BYTES; i++) begin
            hits[i] = '0;
            avail   = win_count - CNT_W'(i);
            for (int d = 0; d < SLOTS; d++) begin
                dl = cfg.lens[d*LEN_CODE_W +: LEN_CODE_W];
                if (dl > LEN_CODE_W'(WIN_BYTES)) begin
                    dl = LEN_CODE_W'(WIN_BYTES);
                end
                ok = (CNT_W'(d) < used) && (dl != '0) && (CNT_W'(i) < win_count)
                     && ({1'b0, dl} <= {1'b0, avail});
                for (int j = 0; j < WIN_BYTES; j++) begin
                    if (LEN_CODE_W'(j) < dl && ext[i+j] != cfg.bytes[d][8*j +: 8]) begin
                        ok = 1'b0;
                    end
                end
                if (ok && !hits[i].hit) begin
                    hits[i].hit = 1'b1;
                    hits[i].num = NUM_W'(d);
                    hits[i].len = dl;
                end
            end
        end
    end

endmodule

// ===== tb/delimiter_text_splitter_core_tb.sv =====
// Self-checking testbench for the delimiter text splitter core: stream driver, chunk checker.
module delimiter_text_splitter_core_tb import dts_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_END = longint'(1) << OFFSET_BITS;

    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
    } text_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = 3'd0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // predictor copy of the registers
    logic [31:0] cfg_delim [4] = '{32'd2570, 32'd10, 32'd9, 32'd8238};
    logic [11:0] cfg_lens  = 12'd1098;
    logic [2:0]  cfg_count = 3'd3;

    // predictor copy of the text state
    logic [23:0] held        = '0;
    int          fill        = 0;
    longint      text_pos    = 0;
    longint      chunk_begin = 0;
    int          skip_left   = 0;
    bit          over_seen   = 1'b0;

    text_beat_t  text_q [$];
    res_t        chunk_q [$];
    text_beat_t  beat_out;
    res_t        want;
    logic [7:0]  sym [3];
    int          send_gap   = 0;
    int          recv_gap   = 0;
    bit          idle_on    = 1'b1;
    int          mismatches = 0;

    delimiter_text_splitter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int try_delims_at(logic [31:0] wv, int avail, longint q);
        int          cnt;
        int          len;
        logic [31:0] mask;
        longint      stop;
        res_t        r;
        cnt = (cfg_count < SLOTS) ? int'(cfg_count) : SLOTS;
        if (skip_left > 0) begin
            skip_left--;
            return 0;
        end
        for (int d = 0; d < cnt; d++) begin
            len = int'((cfg_lens >> (LEN_CODE_W * d)) & 12'd7);
            if (len > WIN_BYTES) len = WIN_BYTES;
            if (len == 0 || len > avail) continue;
            mask = (len == 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * len)) - 32'h1;
            if (((wv ^ cfg_delim[d]) & mask) == 32'h0) begin
                stop = q + len;
                if (stop > POS_END) stop = POS_END;
                r = '0;
                r.chunk_offset       = OFFSET_BITS'(chunk_begin);
                r.chunk_length       = (stop > chunk_begin) ? POS_W'(stop - chunk_begin) : '0;
                r.ended_by_delimiter = 1'b1;
                r.delimiter_number   = NUM_W'(d);
                r.too_long           = over_seen;
                chunk_q.push_back(r);
                chunk_begin = (stop < POS_END - 1) ? stop : POS_END - 1;
                skip_left   = len - 1;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void split_byte(logic [7:0] b, logic last);
        logic [31:0] wv;
        int          n;
        int          found;
        longint      base;
        res_t        r;
        if (text_pos >= POS_END) over_seen = 1'b1;
        else text_pos++;
        if (fill > 3) fill = 3;
        wv = {8'h00, held};
        wv[8 * fill +: 8] = b;
        n = fill + 1;
        base = (text_pos >= n) ? text_pos - n : 0;
        if (!last) begin
            if (n == WIN_BYTES) begin
                void'(try_delims_at(wv, WIN_BYTES, base));
                held = wv[31:8];
                fill = 3;
            end else begin
                held = wv[23:0];
                fill = n;
            end
        end else begin
            found = 0;
            for (int i = 0; i < n; i++)
                found += try_delims_at(wv >> (8 * i), n - i, base + i);
            if (found < NRES) begin
                r = '0;
                r.chunk_offset = OFFSET_BITS'(chunk_begin);
                r.chunk_length = (text_pos > chunk_begin) ? POS_W'(text_pos - chunk_begin) : '0;
                r.too_long     = over_seen;
                chunk_q.push_back(r);
            end
            r = chunk_q.pop_back();
            r.final_chunk = 1'b1;
            chunk_q.push_back(r);
            held        = '0;
            fill        = 0;
            text_pos    = 0;
            chunk_begin = 0;
            skip_left   = 0;
            over_seen   = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_val);
        $display("ERROR %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    // driver: hold a beat until accepted, then advance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) split_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    beat_out = text_q.pop_front();
                    s_tdata  <= beat_out.ch;
                    s_tlast  <= beat_out.eot;
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest expected chunk
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (chunk_q.size() == 0) begin
                    report_mismatch("result beat with no chunk pending", m_tdata[19:0], 0);
                end else begin
                    want = chunk_q.pop_front();
                    if (m_tdata[19:0] !== want.chunk_offset)
                        report_mismatch("chunk_offset", m_tdata[19:0], want.chunk_offset);
                    if (m_tdata[40:20] !== want.chunk_length)
                        report_mismatch("chunk_length", m_tdata[40:20], want.chunk_length);
                    if (m_tuser[0] !== want.ended_by_delimiter)
                        report_mismatch("ended_by_delimiter", m_tuser[0], want.ended_by_delimiter);
                    if (m_tuser[2:1] !== want.delimiter_number)
                        report_mismatch("delimiter_number", m_tuser[2:1], want.delimiter_number);
                    if (m_tuser[3] !== want.too_long)
                        report_mismatch("too_long", m_tuser[3], want.too_long);
                    if (m_tlast !== want.final_chunk)
                        report_mismatch("final_chunk", m_tlast, want.final_chunk);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 19);
            end
        end
    end

    task automatic send(logic [7:0] b, logic last);
        text_beat_t t;
        t.eot = last;
        t.ch  = b;
        text_q.push_back(t);
    endtask

    task automatic send_str(string s, bit ends);
        for (int i = 0; i < s.len(); i++)
            send(s[i], ends && (i == s.len() - 1));
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DELIM0:  cfg_delim[0] = val;
            REG_DELIM1:  cfg_delim[1] = val;
            REG_DELIM2:  cfg_delim[2] = val;
            REG_DELIM3:  cfg_delim[3] = val;
            REG_LENGTHS: cfg_lens = val[11:0];
            REG_COUNT:   cfg_count = val[2:0];
            default: ;
        endcase
    endtask

    task automatic load_delims(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                               logic [31:0] d3, logic [11:0] lens, logic [2:0] cnt);
        write_reg(REG_DELIM0, d0);
        write_reg(REG_DELIM1, d1);
        write_reg(REG_DELIM2, d2);
        write_reg(REG_DELIM3, d3);
        write_reg(REG_LENGTHS, {20'd0, lens});
        write_reg(REG_COUNT, {29'd0, cnt});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (text_q.size() != 0 || s_tvalid || chunk_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic random_setup(int kind);
        logic [31:0] dl [4];
        logic [11:0] lens;
        logic [2:0]  cnt;
        sym[0] = 8'($urandom_range(0, 255));
        sym[1] = 8'($urandom_range(0, 255));
        sym[2] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) dl[k][8 * j +: 8] = sym[$urandom_range(0, 2)];
            lens[3 * k +: 3] = $urandom_range(0, 1) ? 3'($urandom_range(1, 3))
                                                    : 3'($urandom_range(0, 7));
        end
        cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4));
        if (kind == 0) begin
            sym[0] = 8'h00;
            sym[1] = 8'hFF;
            dl     = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
            lens   = 12'hFFF;
            cnt    = 3'd7;
        end else if (kind == 1) begin
            dl   = '{32'h0, 32'h0, 32'h0, 32'h0};
            lens = 12'h000;
            cnt  = 3'd0;
        end
        load_delims(dl[0], dl[1], dl[2], dl[3], lens, cnt);
    endtask

    task automatic random_text(output int len);
        logic [7:0] b;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : sym[$urandom_range(0, 2)];
            send(b, i == len - 1);
        end
    endtask

    initial begin
        #60_000_000;
        $display("delimiter_text_splitter_core regression: fail");
        $finish;
    end

    initial begin
        int sent;
        int len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset delimiters: blank line, newline, tab
        send_str("a\n\nb\tc\n", 1'b1);
        send(8'h00, 1'b1);
        send(8'hFF, 1'b0);
        send_str("\n", 1'b1);
        wait_drained();

        // four one-byte delimiters all hit on the end-of-text beat
        load_delims("x", "y", "z", "w", 12'o1111, 3'd4);
        send_str("abxyzw", 1'b1);
        wait_drained();

        // zero length code, oversized code, count past slots, delimiter past text end
        load_delims(32'h6463_6261, 32'h6463_6261, 32'h7372_7170, 32'h7A7A_6261,
                    12'o2570, 3'd7);
        send_str("abcdxpqab", 1'b1);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) idle_on = 1'b0;
            random_setup(ph);
            sent = 0;
            while (sent < 28) begin
                random_text(len);
                sent += len;
            end
            wait_drained();
        end
        repeat (10) @(negedge aclk);

        if (mismatches == 0)
            $display("delimiter_text_splitter_core regression: pass");
        else
            $display("delimiter_text_splitter_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dts_pkg.sv
rtl/dts_match.sv
rtl/delimiter_text_splitter_core.sv
tb/delimiter_text_splitter_core_tb.sv
